### rtl/core/fsh_pkg.sv
// ----------------------------------------------------------------------------
// fsh_pkg
// Shared types, constants and helpers of the frame statistics histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package fsh_pkg;

   localparam int MAX_BINS   = 64;
   localparam int BIN_AW     = 6;
   localparam int COORD_BITS = 12;
   localparam int COUNT_BITS = 25;
   localparam int OUT_CNT_W  = 25;
   localparam int VAL_W      = 17;
   localparam int SUM_W      = 41;
   localparam int QUOT_W     = 7;
   localparam int NUM_W      = 25;
   localparam int DEN_W      = 18;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [OUT_CNT_W-1:0]  OUT_MAX   = {OUT_CNT_W{1'b1}};
   localparam logic signed [SUM_W:0] SUM_HI    = {2'b00, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W:0] SUM_LO    = {2'b11, {(SUM_W-1){1'b0}}};

   localparam logic KIND_TOTALS = 1'b0;
   localparam logic KIND_BIN    = 1'b1;

   localparam logic [1:0] BG_NONE = 2'd0;
   localparam logic [1:0] BG_SUB  = 2'd1;

   typedef enum logic [2:0] {
      CSR_BG_MODE, CSR_THR_EN, CSR_THR_LEVEL, CSR_HIST_EN,
      CSR_HIST_MIN, CSR_HIST_MAX, CSR_HIST_BINS, CSR_ROI_RECT
   } csr_index_type;

   typedef enum logic [1:0] {OP_PIXEL, OP_REPORT, OP_READ, OP_CLEAR} op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PIX, ST_DIV, ST_RPT, ST_RD, ST_RDOUT
   } state_type;

   typedef enum logic [1:0] {HC_NONE, HC_READ, HC_INC, HC_CLEAR} hist_op_type;

   typedef struct packed {
      hist_op_type         op;
      logic [BIN_AW-1:0]   addr;
   } hist_cmd_type;

   typedef struct packed {
      logic                  pending;
      logic [COUNT_BITS-1:0] rd_data;
   } hist_status_type;

   function automatic logic [COUNT_BITS-1:0] inc_sat(input logic [COUNT_BITS-1:0] c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic logic [OUT_CNT_W-1:0] out_count(input logic [COUNT_BITS-1:0] c);
      return (c > COUNT_BITS'(OUT_MAX)) ? OUT_MAX : OUT_CNT_W'(c);
   endfunction

endpackage

`default_nettype wire

### rtl/core/fsh_div.sv
// ----------------------------------------------------------------------------
// fsh_div
// Restoring divider, one quotient bit per cycle, for the bin choice.
// ----------------------------------------------------------------------------
`default_nettype none

module fsh_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [fsh_pkg::NUM_W-1:0]  num,
   input  wire logic [fsh_pkg::DEN_W-1:0]  den,
   output logic                            done,
   output logic [fsh_pkg::QUOT_W-1:0]      quot
);
   import fsh_pkg::*;

   logic [NUM_W-1:0]  rem_ff, rem_in, dd_ff, dd_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              run_ff, run_in, done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dd_in   = dd_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = num;
         dd_in  = NUM_W'(den) << (QUOT_W - 1);
         q_in   = '0;
         cnt_in = 3'(QUOT_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_ff >= dd_ff) begin
            rem_in = rem_ff - dd_ff;
            q_in   = {q_ff[QUOT_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUOT_W-2:0], 1'b0};
         end
         dd_in  = dd_ff >> 1;
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dd_ff  <= dd_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff) else $error("divider restarted while running");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff) else $error("divider done while running");
   a_runs_out: assert property (@(posedge clock) disable iff (reset)
      (run_ff && cnt_ff == 3'd1 && !start) |=> done_ff)
      else $error("divider missed done");

endmodule

`default_nettype wire

### rtl/core/fsh_hist.sv
// ----------------------------------------------------------------------------
// fsh_hist
// Histogram bin memory with per-bin valid bits; read and
// read-increment-write of one bin, and clear of all bins.
// ----------------------------------------------------------------------------
`default_nettype none

module fsh_hist (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire fsh_pkg::hist_cmd_type    cmd,
   output fsh_pkg::hist_status_type      status
);
   import fsh_pkg::*;

   logic [COUNT_BITS-1:0] mem [MAX_BINS];
   logic [MAX_BINS-1:0]   valid_ff;
   logic [COUNT_BITS-1:0] rd_ff, rd_data, wr_data;
   logic                  rd_valid_ff, pend_ff;
   logic [BIN_AW-1:0]     addr_ff;

   assign rd_data = rd_valid_ff ? rd_ff : '0;
   assign wr_data = inc_sat(rd_data);

   always_ff @(posedge clock) begin
      rd_ff       <= mem[cmd.addr];
      rd_valid_ff <= valid_ff[cmd.addr];
      addr_ff     <= cmd.addr;
      if (pend_ff) begin
         mem[addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         pend_ff <= (cmd.op == HC_INC);
         if (cmd.op == HC_CLEAR) begin
            valid_ff <= '0;
         end else if (pend_ff) begin
            valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   assign status.pending = pend_ff;
   assign status.rd_data = rd_data;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> cmd.op == HC_NONE) else $error("bin access during write-back");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.op == HC_CLEAR |=> valid_ff == '0) else $error("clear left valid bins");
   a_wb_valid: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> valid_ff[$past(addr_ff)]) else $error("written bin not valid");

endmodule

`default_nettype wire

### rtl/core/frame_statistics_histogram.sv
// ----------------------------------------------------------------------------
// frame_statistics_histogram
// Frame statistics (count, min, max, sums, threshold, ROI) and histogram.
//
//   channel  ports                      handshake
//   req      req_op .. req_bin_index    start, accepted when busy is low
//   rsp      rsp_kind .. rsp_bin_value  rsp_valid strobe, one cycle
//   csr      csr_index, csr_write_data  csr_write_enable, no wait
//
// Pixel beat: ST_PIX, then, when it lands in the histogram, the 7-step divider
// and a read and write-back of the bin memory. Report: ST_RPT.
// Bin read: ST_RD and ST_RDOUT through the memory read port. Clear: on accept.
// Reset clears all statistics and bins at once (per-bin valid bits).
// A totals result strobes from the result register after ST_RPT, a bin result
// after ST_RD and ST_RDOUT; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_statistics_histogram (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [1:0]                         req_op,
   input  wire logic [15:0]                        req_sample,
   input  wire logic [15:0]                        req_bg_sample,
   input  wire logic [11:0]                        req_pixel_x,
   input  wire logic [11:0]                        req_pixel_y,
   input  wire logic [5:0]                         req_bin_index,
   input  wire logic                               csr_write_enable,
   input  wire logic [2:0]                         csr_index,
   input  wire logic [63:0]                        csr_write_data,
   output logic                                    rsp_valid,
   output logic                                    rsp_kind,
   output logic [24:0]                             rsp_pixel_count,
   output logic [24:0]                             rsp_nonzero_count,
   output logic [24:0]                             rsp_threshold_count,
   output logic signed [16:0]                      rsp_min_value,
   output logic signed [16:0]                      rsp_max_value,
   output logic signed [16:0]                      rsp_min_nonzero,
   output logic signed [40:0]                      rsp_value_sum,
   output logic [24:0]                             rsp_roi_count,
   output logic signed [40:0]                      rsp_roi_sum,
   output logic [24:0]                             rsp_bin_value
);
   import fsh_pkg::*;

   // configuration
   logic [1:0]              bg_mode_ff;
   logic                    thr_en_ff, hist_en_ff;
   logic signed [VAL_W-1:0] thr_ff, hmin_ff, hmax_ff;
   logic [6:0]              bins_ff;
   logic [63:0]             roi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_mode_ff <= BG_NONE;
         thr_en_ff  <= 1'b0;
         thr_ff     <= '0;
         hist_en_ff <= 1'b0;
         hmin_ff    <= '0;
         hmax_ff    <= 17'sd65535;
         bins_ff    <= 7'd64;
         roi_ff     <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_BG_MODE:   bg_mode_ff <= csr_write_data[1:0];
            CSR_THR_EN:    thr_en_ff  <= csr_write_data[0];
            CSR_THR_LEVEL: thr_ff     <= csr_write_data[VAL_W-1:0];
            CSR_HIST_EN:   hist_en_ff <= csr_write_data[0];
            CSR_HIST_MIN:  hmin_ff    <= csr_write_data[VAL_W-1:0];
            CSR_HIST_MAX:  hmax_ff    <= csr_write_data[VAL_W-1:0];
            CSR_HIST_BINS: bins_ff    <= csr_write_data[6:0];
            CSR_ROI_RECT:  roi_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   // FSM
   state_type       state_ff, state_in;
   logic            accept;
   hist_cmd_type    hcmd;
   hist_status_type hstat;
   logic            div_start, div_done;
   logic [QUOT_W-1:0] quot;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE) || hstat.pending;

   // latched beat
   logic signed [VAL_W-1:0] v_ff, v_in;
   logic [COORD_BITS-1:0]   x_ff, y_ff;
   logic [BIN_AW-1:0]       idx_ff;

   always_comb begin
      v_in = signed'({1'b0, req_sample});
      if (bg_mode_ff != BG_NONE) begin
         v_in = v_in - signed'({1'b0, req_bg_sample});
         if (bg_mode_ff != BG_SUB && v_in < 0) begin
            v_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         v_ff   <= v_in;
         x_ff   <= req_pixel_x[COORD_BITS-1:0];
         y_ff   <= req_pixel_y[COORD_BITS-1:0];
         idx_ff <= req_bin_index[BIN_AW-1:0];
      end
   end

   // histogram bin setup
   logic [6:0]          bins_eff;
   logic                hist_hit;
   logic [DEN_W-1:0]    diff, den;
   logic [NUM_W-1:0]    num;
   logic [BIN_AW-1:0]   bin_addr;

   assign bins_eff = (bins_ff > 7'(MAX_BINS)) ? 7'(MAX_BINS) : bins_ff;
   assign hist_hit = hist_en_ff && (hmax_ff > hmin_ff) && (bins_eff != '0)
                     && (v_ff >= hmin_ff) && (v_ff <= hmax_ff);
   assign diff     = DEN_W'(v_ff) - DEN_W'(hmin_ff);
   assign den      = DEN_W'(hmax_ff) - DEN_W'(hmin_ff);
   assign num      = NUM_W'(diff) * NUM_W'(bins_eff);
   assign bin_addr = (quot >= bins_eff) ? BIN_AW'(bins_eff - 7'd1) : BIN_AW'(quot);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op_type'(req_op))
                  OP_PIXEL:  state_in = ST_PIX;
                  OP_REPORT: state_in = ST_RPT;
                  OP_READ:   state_in = ST_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_PIX:   state_in = hist_hit ? ST_DIV : ST_IDLE;
         ST_DIV:   state_in = div_done ? ST_IDLE : ST_DIV;
         ST_RPT:   state_in = ST_IDLE;
         ST_RD:    state_in = ST_RDOUT;
         ST_RDOUT: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      hcmd.op   = HC_NONE;
      hcmd.addr = bin_addr;
      case (state_ff)
         ST_IDLE: begin
            if (accept && op_type'(req_op) == OP_CLEAR) begin
               hcmd.op = HC_CLEAR;
            end
         end
         ST_PIX:  div_start = hist_hit;
         ST_DIV: begin
            if (div_done) begin
               hcmd.op = HC_INC;
            end
         end
         ST_RD: begin
            hcmd.op   = HC_READ;
            hcmd.addr = idx_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   fsh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den),
      .done  (div_done),
      .quot  (quot)
   );

   fsh_hist u_hist (
      .clock  (clock),
      .reset  (reset),
      .cmd    (hcmd),
      .status (hstat)
   );

   // accumulators
   logic [COUNT_BITS-1:0]   cnt_ff, nz_ff, above_ff, roi_cnt_ff;
   logic signed [VAL_W-1:0] min_ff, max_ff, minnz_ff;
   logic signed [SUM_W-1:0] sum_ff, roi_sum_ff;
   logic signed [SUM_W-1:0] sum_in, roi_sum_in;
   logic signed [SUM_W:0]   sum_w, roi_w;
   logic                    in_roi, clear_now;

   assign sum_w = {sum_ff[SUM_W-1], sum_ff} + (SUM_W+1)'(v_ff);
   assign roi_w = {roi_sum_ff[SUM_W-1], roi_sum_ff} + (SUM_W+1)'(v_ff);
   assign sum_in = (sum_w > SUM_HI) ? SUM_W'(SUM_HI) :
                   (sum_w < SUM_LO) ? SUM_W'(SUM_LO) : SUM_W'(sum_w);
   assign roi_sum_in = (roi_w > SUM_HI) ? SUM_W'(SUM_HI) :
                       (roi_w < SUM_LO) ? SUM_W'(SUM_LO) : SUM_W'(roi_w);
   assign in_roi = (16'(x_ff) >= roi_ff[15:0]) && (16'(x_ff) < roi_ff[47:32])
                   && (16'(y_ff) >= roi_ff[31:16]) && (16'(y_ff) < roi_ff[63:48]);
   assign clear_now = accept && op_type'(req_op) == OP_CLEAR;

   always_ff @(posedge clock) begin
      if (reset || clear_now) begin
         cnt_ff     <= '0;
         nz_ff      <= '0;
         above_ff   <= '0;
         roi_cnt_ff <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         minnz_ff   <= '0;
         sum_ff     <= '0;
         roi_sum_ff <= '0;
      end else if (state_ff == ST_PIX) begin
         if (cnt_ff == '0 || v_ff < min_ff) min_ff <= v_ff;
         if (cnt_ff == '0 || v_ff > max_ff) max_ff <= v_ff;
         cnt_ff <= inc_sat(cnt_ff);
         if (v_ff != '0) begin
            if (nz_ff == '0 || v_ff < minnz_ff) minnz_ff <= v_ff;
            nz_ff <= inc_sat(nz_ff);
         end
         sum_ff <= sum_in;
         if (thr_en_ff && v_ff >= thr_ff) above_ff <= inc_sat(above_ff);
         if (in_roi) begin
            roi_cnt_ff <= inc_sat(roi_cnt_ff);
            roi_sum_ff <= roi_sum_in;
         end
      end
   end

   // result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_RPT) || (state_ff == ST_RDOUT);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RPT) begin
         rsp_kind            <= KIND_TOTALS;
         rsp_pixel_count     <= out_count(cnt_ff);
         rsp_nonzero_count   <= out_count(nz_ff);
         rsp_threshold_count <= thr_en_ff ? out_count(above_ff) : '0;
         rsp_min_value       <= (cnt_ff != '0) ? min_ff : '0;
         rsp_max_value       <= (cnt_ff != '0) ? max_ff : '0;
         rsp_min_nonzero     <= (nz_ff != '0) ? minnz_ff : '0;
         rsp_value_sum       <= sum_ff;
         rsp_roi_count       <= out_count(roi_cnt_ff);
         rsp_roi_sum         <= roi_sum_ff;
         rsp_bin_value       <= '0;
      end else if (state_ff == ST_RDOUT) begin
         rsp_kind            <= KIND_BIN;
         rsp_pixel_count     <= '0;
         rsp_nonzero_count   <= '0;
         rsp_threshold_count <= '0;
         rsp_min_value       <= '0;
         rsp_max_value       <= '0;
         rsp_min_nonzero     <= '0;
         rsp_value_sum       <= '0;
         rsp_roi_count       <= '0;
         rsp_roi_sum         <= '0;
         rsp_bin_value       <= out_count(hstat.rd_data);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_RPT || state_ff == ST_RDOUT))
      else $error("result without report or read");
   a_busy_pix: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PIX && hist_hit |=> busy) else $error("idle during binning");
   a_div_once: assert property (@(posedge clock) disable iff (reset)
      div_start |-> state_ff == ST_PIX) else $error("divider started outside pixel");

endmodule

`default_nettype wire

### sim/frame_statistics_histogram_tb.sv
// ----------------------------------------------------------------------------
// frame_statistics_histogram_tb
// Self-checking bench for the frame statistics and histogram unit. A queue of
// pixel, report, bin-read and clear beats feeds a start/busy driver; a shadow
// model of the accumulators and bins predicts each report and bin read, and a
// monitor compares every rsp_valid strobe field by field. Register settings
// change between phases, only while the unit is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_statistics_histogram_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsh_pkg::*;

   typedef struct {
      op_type      op;
      logic [15:0] sample;
      logic [15:0] bg;
      logic [11:0] x;
      logic [11:0] y;
      logic [5:0]  bin;
   } beat_type;

   typedef struct {
      logic               kind;
      logic [24:0]        cnt, nz, thr, roi_cnt, bin_val;
      logic [16:0]        mn, mx, mnz;
      logic [40:0]        sum, roi_sum;
   } stats_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = '0;
   logic [15:0] req_sample = '0, req_bg_sample = '0;
   logic [11:0] req_pixel_x = '0, req_pixel_y = '0;
   logic [5:0]  req_bin_index = '0;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_write_data = '0;
   logic        rsp_valid, rsp_kind;
   logic [24:0] rsp_pixel_count, rsp_nonzero_count, rsp_threshold_count;
   logic signed [16:0] rsp_min_value, rsp_max_value, rsp_min_nonzero;
   logic signed [40:0] rsp_value_sum, rsp_roi_sum;
   logic [24:0] rsp_roi_count, rsp_bin_value;

   frame_statistics_histogram dut (.*);

   always #5 clock = ~clock;

   // register shadow
   logic [1:0]  bg_mode;
   logic        thr_en, hist_en;
   logic [16:0] thr_level, hist_lo, hist_hi;
   logic [6:0]  hist_bins;
   logic [63:0] roi;

   // accumulator shadow
   longint unsigned n_pix, n_nz, n_above, n_roi;
   longint          v_min, v_max, v_min_nz, v_sum, v_roi_sum;
   longint unsigned bin_count [MAX_BINS];

   beat_type  pending_beats[$];
   stats_type expected_stats[$];
   beat_type  cur;
   bit        calm = 1'b0;
   int        mismatches = 0;

   function automatic longint sx17(logic [16:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint unsigned bump(longint unsigned c);
      return (c < longint'(COUNT_MAX)) ? c + 1 : c;
   endfunction

   function automatic longint sum_clip(longint s);
      if (s > 64'sh0FF_FFFF_FFFF) return 64'sh0FF_FFFF_FFFF;
      if (s < -64'sh100_0000_0000) return -64'sh100_0000_0000;
      return s;
   endfunction

   function automatic logic [24:0] clip_count(longint unsigned c);
      return (c > 64'h1FF_FFFF) ? 25'h1FF_FFFF : 25'(c);
   endfunction

   task automatic wipe_stats();
      n_pix = 0; n_nz = 0; n_above = 0; n_roi = 0;
      v_min = 0; v_max = 0; v_min_nz = 0; v_sum = 0; v_roi_sum = 0;
      foreach (bin_count[i]) bin_count[i] = 0;
   endtask

   task automatic accumulate_beat(beat_type b);
      longint v, lo, hi, k;
      longint unsigned nb;
      stats_type r;
      r = '{default: '0};
      case (b.op)
         OP_PIXEL: begin
            v = b.sample;
            if (bg_mode != BG_NONE) begin
               v = v - b.bg;
               if (bg_mode > BG_SUB && v < 0) v = 0;
            end
            if (n_pix == 0 || v < v_min) v_min = v;
            if (n_pix == 0 || v > v_max) v_max = v;
            n_pix = bump(n_pix);
            if (v != 0) begin
               if (n_nz == 0 || v < v_min_nz) v_min_nz = v;
               n_nz = bump(n_nz);
            end
            v_sum = sum_clip(v_sum + v);
            if (thr_en && v >= sx17(thr_level)) n_above = bump(n_above);
            lo = sx17(hist_lo);
            hi = sx17(hist_hi);
            nb = (hist_bins > MAX_BINS) ? MAX_BINS : hist_bins;
            if (hist_en && hi > lo && nb != 0 && v >= lo && v <= hi) begin
               k = ((v - lo) * longint'(nb)) / (hi - lo);
               if (k >= longint'(nb)) k = nb - 1;
               bin_count[k] = bump(bin_count[k]);
            end
            if (b.x >= roi[15:0] && b.x < roi[47:32] &&
                b.y >= roi[31:16] && b.y < roi[63:48]) begin
               n_roi = bump(n_roi);
               v_roi_sum = sum_clip(v_roi_sum + v);
            end
         end
         OP_CLEAR: wipe_stats();
         OP_REPORT: begin
            r.kind    = KIND_TOTALS;
            r.cnt     = clip_count(n_pix);
            r.nz      = clip_count(n_nz);
            r.thr     = thr_en ? clip_count(n_above) : '0;
            r.mn      = n_pix ? 17'(v_min) : '0;
            r.mx      = n_pix ? 17'(v_max) : '0;
            r.mnz     = n_nz ? 17'(v_min_nz) : '0;
            r.sum     = 41'(v_sum);
            r.roi_cnt = clip_count(n_roi);
            r.roi_sum = 41'(v_roi_sum);
            expected_stats.push_back(r);
         end
         default: begin
            r.kind    = KIND_BIN;
            r.bin_val = clip_count(bin_count[b.bin]);
            expected_stats.push_back(r);
         end
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) accumulate_beat(cur);
         if (!start || !busy) begin
            if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
               cur = pending_beats.pop_front();
               start         <= 1'b1;
               req_op        <= cur.op;
               req_sample    <= cur.sample;
               req_bg_sample <= cur.bg;
               req_pixel_x   <= cur.x;
               req_pixel_y   <= cur.y;
               req_bin_index <= cur.bin;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      stats_type e;
      if (!reset && rsp_valid) begin
         if (expected_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
         end else begin
            e = expected_stats.pop_front();
            if (rsp_kind !== e.kind || rsp_pixel_count !== e.cnt ||
                rsp_nonzero_count !== e.nz || rsp_threshold_count !== e.thr ||
                rsp_min_value !== e.mn || rsp_max_value !== e.mx ||
                rsp_min_nonzero !== e.mnz || rsp_value_sum !== e.sum ||
                rsp_roi_count !== e.roi_cnt || rsp_roi_sum !== e.roi_sum ||
                rsp_bin_value !== e.bin_val) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: exp k%0d c%0d nz%0d t%0d mn%0d mx%0d mnz%0d s%0d rc%0d rs%0d b%0d / got k%0d c%0d nz%0d t%0d mn%0d mx%0d mnz%0d s%0d rc%0d rs%0d b%0d",
                     $realtime, e.kind, e.cnt, e.nz, e.thr, signed'(e.mn), signed'(e.mx),
                     signed'(e.mnz), signed'(e.sum), e.roi_cnt, signed'(e.roi_sum), e.bin_val,
                     rsp_kind, rsp_pixel_count, rsp_nonzero_count, rsp_threshold_count,
                     rsp_min_value, rsp_max_value, rsp_min_nonzero, rsp_value_sum,
                     rsp_roi_count, rsp_roi_sum, rsp_bin_value);
            end
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [63:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_BG_MODE:   bg_mode   = data[1:0];
         CSR_THR_EN:    thr_en    = data[0];
         CSR_THR_LEVEL: thr_level = data[16:0];
         CSR_HIST_EN:   hist_en   = data[0];
         CSR_HIST_MIN:  hist_lo   = data[16:0];
         CSR_HIST_MAX:  hist_hi   = data[16:0];
         CSR_HIST_BINS: hist_bins = data[6:0];
         default:       roi       = data;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic setup(int bgm, int te, int tl, int he, int lo, int hi, int nb,
                        logic [63:0] rect);
      write_reg(CSR_BG_MODE, 64'(bgm));
      write_reg(CSR_THR_EN, 64'(te));
      write_reg(CSR_THR_LEVEL, 64'(tl));
      write_reg(CSR_HIST_EN, 64'(he));
      write_reg(CSR_HIST_MIN, 64'(lo));
      write_reg(CSR_HIST_MAX, 64'(hi));
      write_reg(CSR_HIST_BINS, 64'(nb));
      write_reg(CSR_ROI_RECT, rect);
   endtask

   task automatic push(op_type op, int s, int bgv, int x, int y, int bin);
      beat_type b;
      b.op = op; b.sample = 16'(s); b.bg = 16'(bgv);
      b.x = 12'(x); b.y = 12'(y); b.bin = 6'(bin);
      pending_beats.push_back(b);
   endtask

   task automatic random_beats(int n);
      beat_type b;
      int       r;
      repeat (n) begin
         r = $urandom_range(99);
         b.op = (r < 72) ? OP_PIXEL : (r < 84) ? OP_REPORT : (r < 97) ? OP_READ : OP_CLEAR;
         case ($urandom_range(9))
            0:       b.sample = 16'hFFFF;
            1:       b.sample = '0;
            default: b.sample = 16'($urandom);
         endcase
         b.bg = ($urandom_range(4) == 0) ? b.sample : 16'($urandom);
         if ($urandom_range(1)) begin
            b.x = 12'($urandom_range(roi[15:0] > 4095 ? 4095 : roi[15:0],
                                     roi[47:32] > 4095 ? 4095 : roi[47:32]));
            b.y = 12'($urandom_range(roi[31:16] > 4095 ? 4095 : roi[31:16],
                                     roi[63:48] > 4095 ? 4095 : roi[63:48]));
         end else begin
            b.x = 12'($urandom);
            b.y = 12'($urandom);
         end
         b.bin = 6'($urandom);
         pending_beats.push_back(b);
      end
   endtask

   task automatic drain();
      while (pending_beats.size() > 0 || start || expected_stats.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      bg_mode = '0; thr_en = 0; thr_level = '0; hist_en = 0;
      hist_lo = '0; hist_hi = 17'd65535; hist_bins = 7'd64; roi = '0;
      wipe_stats();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty report, extremes, every op, mode three clamp
      setup(3, 1, 0, 1, -65535, 65535, 64, {16'd100, 16'd100, 16'd0, 16'd0});
      push(OP_REPORT, 0, 0, 0, 0, 0);
      push(OP_READ, 0, 0, 0, 0, 63);
      push(OP_PIXEL, 0, 0, 0, 0, 0);
      push(OP_PIXEL, 65535, 0, 4095, 4095, 0);
      push(OP_PIXEL, 0, 65535, 99, 99, 0);
      push(OP_PIXEL, 65535, 65535, 100, 5, 0);
      push(OP_PIXEL, 1, 0, 5, 100, 0);
      push(OP_REPORT, 0, 0, 0, 0, 0);
      push(OP_READ, 0, 0, 0, 0, 0);
      push(OP_READ, 0, 0, 0, 0, 32);
      push(OP_READ, 0, 0, 0, 0, 63);
      push(OP_CLEAR, 0, 0, 0, 0, 0);
      push(OP_REPORT, 0, 0, 0, 0, 0);
      push(OP_READ, 0, 0, 0, 0, 0);
      drain();

      setup(1, 1, -65535, 1, -65535, 65535, 64, {16'd4095, 16'd4095, 16'd0, 16'd0});
      push(OP_PIXEL, 0, 65535, 7, 7, 0);
      push(OP_PIXEL, 65535, 0, 4094, 4094, 0);
      push(OP_PIXEL, 0, 1, 1, 1, 0);
      push(OP_REPORT, 0, 0, 0, 0, 0);
      push(OP_READ, 0, 0, 0, 0, 0);
      push(OP_READ, 0, 0, 0, 0, 63);
      random_beats(100);
      drain();

      calm = 1'b1;
      setup(2, 1, 65535, 1, 0, 65535, 1, {16'd3000, 16'd2000, 16'd1000, 16'd500});
      random_beats(100);
      drain();
      calm = 1'b0;

      setup(0, 1, 30000, 1, 1000, 60000, 127, 64'($urandom) << 32 | 64'($urandom));
      random_beats(100);
      drain();

      setup(1, 0, 100, 1, 500, 500, 64, {16'd0, 16'd0, 16'd0, 16'd0});
      random_beats(100);
      drain();

      setup(1, 1, -100, 1, -2000, 2000, 13, {16'd800, 16'd900, 16'd100, 16'd50});
      random_beats(120);
      drain();

      setup(3, 1, 1, 1, 0, 100, 0, {16'hFFFF, 16'hFFFF, 16'd0, 16'd0});
      random_beats(100);
      drain();

      setup(0, 1, 0, 1, 0, 65535, 37, {16'd2048, 16'd4095, 16'd1, 16'd0});
      random_beats(100);
      drain();

      setup(1, 1, 5, 0, -65535, 65535, 64, 64'($urandom) << 32 | 64'($urandom));
      random_beats(100);
      drain();

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
